// ===== hw/rtl/hdt_pkg.sv =====
// Shared types and constants for the hashed directory table.
// Used by hdt_ctrl, hdt_datapath and hashed_directory_table.
package hdt_pkg;

    localparam int SLOTS      = 256;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    localparam int HASH_BITS  = 32;
    localparam int HASH_CNT_W = $clog2(HASH_BITS);

    localparam logic [31:0] HEADER_SIZE = 32'd32;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_SPACE     = 2'd3;

    typedef struct packed {
        logic [31:0] key_a;
        logic [31:0] key_b;
        logic [31:0] position;
        logic [31:0] comp_len;
        logic [31:0] orig_len;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;       // latch request; set home slot if SLOTS is a power of two
        logic       hash_step;  // one bit of home_hash mod SLOTS
        logic       rd_en;      // read slot at current index
        logic       advance;    // step to next slot, wrapping
        logic       res_none;   // result with status only
        logic [1:0] res_code;   // status for res_none
        logic       res_slot;   // result from the slot just read
        logic       del;        // empty the current slot
        logic       ins;        // place the entry in the current slot, if it fits
        logic       out_load;   // move the result to the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic hash_last;
        logic used;
        logic match;
        logic probe_last;
    } stat_t;

endpackage

// ===== hw/rtl/hashed_directory_table.sv =====
// Hashed directory table: open-addressed store of archive entries, linear probing.
// Each request is taken, then the home-slot remainder is found if SLOTS is not
// a power of two (skipped otherwise); each probed slot gets a registered read of
// the slot RAM and a compare; an insert adds a write; then the result is posted.
// Throughput: one transaction at a time, set by the probe walk over the RAM port.
// Reset clears all occupancy bits at once and sets the append pointer to 32.
module hashed_directory_table (
    input  logic        clk,
    input  logic        rst_n,

    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [31:0] key_a,
    input  logic [31:0] key_b,
    input  logic [31:0] home_hash,
    input  logic [31:0] orig_len,
    input  logic [31:0] comp_len,

    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  slot,
    output logic [31:0] position,
    output logic [31:0] stored_comp_len,
    output logic [31:0] stored_orig_len
);

    import hdt_pkg::*;

    // Controller walks the probe sequence; datapath holds slots and results.
    cmd_t  cmd;
    stat_t stat;

    // The controller owns both handshakes. A finished result moves into the
    // output register as soon as that register is free, so the next request
    // transaction can be taken while a result still waits downstream.
    hdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Occupancy is tracked by one flip-flop per slot; an empty slot never
    // matches, whatever its stored key words hold. Deletes drop the bit only.
    hdt_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .key_a           (key_a),
        .key_b           (key_b),
        .home_hash       (home_hash),
        .orig_len        (orig_len),
        .comp_len        (comp_len),
        .status          (status),
        .slot            (slot),
        .position        (position),
        .stored_comp_len (stored_comp_len),
        .stored_orig_len (stored_orig_len)
    );

endmodule

// ===== hw/rtl/hdt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hdt_datapath.sv =====
// Datapath of the hashed directory table: request registers, home-slot
// remainder, slot store with occupancy bits, append pointer, result registers.
// Depends on hdt_pkg and hdt_ram.
module hdt_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  hdt_pkg::cmd_t      cmd,
    output hdt_pkg::stat_t     stat,
    input  logic [31:0]        key_a,
    input  logic [31:0]        key_b,
    input  logic [31:0]        home_hash,
    input  logic [31:0]        orig_len,
    input  logic [31:0]        comp_len,
    output logic [1:0]         status,
    output logic [7:0]         slot,
    output logic [31:0]        position,
    output logic [31:0]        stored_comp_len,
    output logic [31:0]        stored_orig_len
);

    import hdt_pkg::*;

    localparam logic [CNT_W-1:0]      SLOTS_CNT = CNT_W'(SLOTS);
    localparam logic [IDX_W-1:0]      IDX_LAST  = IDX_W'(SLOTS - 1);
    localparam logic [HASH_CNT_W-1:0] HASH_LAST = HASH_CNT_W'(HASH_BITS - 1);

    // request
    logic [31:0] key_a_reg, key_b_reg, orig_len_reg, comp_len_reg;

    // probe state
    logic [IDX_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      rem_reg;
    logic [31:0]           hash_sh_reg;
    logic [HASH_CNT_W-1:0] hash_cnt_reg;

    // directory state
    logic [SLOTS-1:0] valid_reg;
    logic [31:0]      append_ptr_reg;

    // staged and output result
    logic [1:0]  res_status_reg, out_status_reg;
    logic [7:0]  res_slot_reg, out_slot_reg;
    logic [31:0] res_pos_reg, out_pos_reg;
    logic [31:0] res_clen_reg, out_clen_reg;
    logic [31:0] res_olen_reg, out_olen_reg;

    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;
    entry_t             wr_entry;
    logic               used;
    logic               key_hit;
    logic               reuse;
    logic [32:0]        append_sum;
    logic               ins_fail;
    logic [31:0]        new_pos;
    logic [IDX_W-1:0]   idx_inc;
    logic [IDX_W:0]     rem_sh;
    logic [IDX_W:0]     rem_sub;
    logic [IDX_W-1:0]   rem_next;

    always_comb
    begin
        rd_entry   = entry_t'(ram_rdata);
        used       = valid_reg[idx_reg];
        key_hit    = (rd_entry.key_a == key_a_reg) && (rd_entry.key_b == key_b_reg);
        reuse      = used && (comp_len_reg <= rd_entry.comp_len);
        append_sum = {1'b0, append_ptr_reg} + {1'b0, comp_len_reg};
        ins_fail   = (comp_len_reg == 32'd0) || (!reuse && append_sum[32]);
        new_pos    = reuse ? rd_entry.position : append_ptr_reg;

        wr_entry.key_a    = key_a_reg;
        wr_entry.key_b    = key_b_reg;
        wr_entry.position = new_pos;
        wr_entry.comp_len = comp_len_reg;
        wr_entry.orig_len = orig_len_reg;

        idx_inc  = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;

        // restoring remainder, one hash bit per step
        rem_sh   = {rem_reg, hash_sh_reg[31]};
        rem_sub  = rem_sh - SLOTS_CNT;
        rem_next = (rem_sh >= SLOTS_CNT) ? rem_sub[IDX_W-1:0] : rem_sh[IDX_W-1:0];

        stat.hash_last  = (hash_cnt_reg == HASH_LAST);
        stat.used       = used;
        stat.match      = used && key_hit;
        stat.probe_last = (cnt_reg == SLOTS_CNT);
    end

    hdt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (cmd.ins && !ins_fail),
        .waddr (idx_reg),
        .wdata (wr_entry),
        .re    (cmd.rd_en),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            append_ptr_reg <= HEADER_SIZE;
        end
        else
        begin
            if (cmd.del)
            begin
                valid_reg[idx_reg] <= 1'b0;
            end
            if (cmd.ins && !ins_fail)
            begin
                valid_reg[idx_reg] <= 1'b1;
                if (!reuse)
                begin
                    append_ptr_reg <= append_sum[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_a_reg    <= key_a;
            key_b_reg    <= key_b;
            orig_len_reg <= orig_len;
            comp_len_reg <= comp_len;
            cnt_reg      <= '0;
            rem_reg      <= '0;
            hash_sh_reg  <= home_hash;
            hash_cnt_reg <= '0;
            if (SLOTS_POW2)
            begin
                idx_reg <= home_hash[IDX_W-1:0];
            end
        end
        if (cmd.hash_step)
        begin
            rem_reg      <= rem_next;
            hash_sh_reg  <= {hash_sh_reg[30:0], 1'b0};
            hash_cnt_reg <= hash_cnt_reg + 1'b1;
            if (hash_cnt_reg == HASH_LAST)
            begin
                idx_reg <= rem_next;
            end
        end
        if (cmd.rd_en)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.advance)
        begin
            idx_reg <= idx_inc;
        end

        if (cmd.res_none)
        begin
            res_status_reg <= cmd.res_code;
            res_slot_reg   <= '0;
            res_pos_reg    <= '0;
            res_clen_reg   <= '0;
            res_olen_reg   <= '0;
        end
        if (cmd.res_slot)
        begin
            res_status_reg <= ST_OK;
            res_slot_reg   <= 8'(idx_reg);
            res_pos_reg    <= rd_entry.position;
            res_clen_reg   <= rd_entry.comp_len;
            res_olen_reg   <= rd_entry.orig_len;
        end
        if (cmd.ins)
        begin
            if (ins_fail)
            begin
                res_status_reg <= ST_SPACE;
                res_slot_reg   <= '0;
                res_pos_reg    <= '0;
                res_clen_reg   <= '0;
                res_olen_reg   <= '0;
            end
            else
            begin
                res_status_reg <= ST_OK;
                res_slot_reg   <= 8'(idx_reg);
                res_pos_reg    <= new_pos;
                res_clen_reg   <= comp_len_reg;
                res_olen_reg   <= orig_len_reg;
            end
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_pos_reg    <= res_pos_reg;
            out_clen_reg   <= res_clen_reg;
            out_olen_reg   <= res_olen_reg;
        end
    end

    assign status          = out_status_reg;
    assign slot            = out_slot_reg;
    assign position        = out_pos_reg;
    assign stored_comp_len = out_clen_reg;
    assign stored_orig_len = out_olen_reg;

endmodule

// ===== hw/rtl/hdt_ctrl.sv =====
// Controller of the hashed directory table: request sequencing, probe walk
// and output handshake. Depends on hdt_pkg.
module hdt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     opcode,
    output logic           out_valid,
    input  logic           out_ready,
    output hdt_pkg::cmd_t  cmd,
    input  hdt_pkg::stat_t stat
);

    import hdt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HASH  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    op_next  = opcode;
                    if (opcode == OP_UNUSED)
                    begin
                        cmd.res_none = 1'b1;
                        cmd.res_code = ST_NOT_FOUND;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = SLOTS_POW2 ? S_READ : S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (stat.hash_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (!stat.used || stat.match)
                    begin
                        state_next = S_WRITE;
                    end
                    else if (stat.probe_last)
                    begin
                        cmd.res_none = 1'b1;
                        cmd.res_code = ST_FULL;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_READ;
                    end
                end
                else if (stat.match)
                begin
                    // report the slot, then empty it for a delete
                    cmd.res_slot = 1'b1;
                    cmd.del      = (op_reg == OP_DELETE);
                    state_next   = S_DONE;
                end
                else if (!stat.used || stat.probe_last)
                begin
                    cmd.res_none = 1'b1;
                    cmd.res_code = ST_NOT_FOUND;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_WRITE:
            begin
                cmd.ins    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_LOOKUP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
